[hdl/row_scan_shift_out_driver_top_defines.svh]
// Assertion macros shared by the row scan shift-out driver.
`ifndef ROW_SCAN_SHIFT_OUT_DRIVER_TOP_DEFINES_SVH
`define ROW_SCAN_SHIFT_OUT_DRIVER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define RSSOD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define RSSOD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rssod_pkg.sv]
// Shared constants and types of the row scan shift-out driver.
package rssod_pkg;

    // Display geometry
    localparam int ROW_COUNT    = 10;
    localparam int ROW_WIDTH    = 25;
    localparam int CHAIN_LENGTH = 31;
    localparam int TOTAL_SHIFTS = (CHAIN_LENGTH > ROW_WIDTH) ? CHAIN_LENGTH : ROW_WIDTH;
    localparam int ROW_IDX_W    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    // Field widths
    localparam int ROW_SEL_W   = 4;
    localparam int ROW_BITS_W  = 25;
    localparam int SHIFT_CNT_W = 5;
    localparam int LATCH_CNT_W = 10;
    localparam int LHIGH_W     = 8;
    localparam int LGAP_W      = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;

    // Request kinds carried in s_tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_HIGH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_GAP     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [LHIGH_W-1:0] LATCH_HIGH_RST = 8'd6;
    localparam logic [LGAP_W-1:0]  LATCH_GAP_RST  = 10'd55;

    // Scan phases
    typedef enum logic [2:0] {
        PH_SHIFT      = 3'b001,
        PH_LATCH_HIGH = 3'b010,
        PH_LATCH_GAP  = 3'b100
    } scan_phase_t;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic               screen_enable;
        logic [LHIGH_W-1:0] latch_high_ticks;
        logic [LGAP_W-1:0]  latch_gap_ticks;
    } rssod_cfg_t;

    // One result; serial_data lands in bit 0 when cast to m_tdata
    typedef struct packed {
        logic [ROW_SEL_W-1:0] current_row;
        logic                 output_enable_n;
        logic                 latch_clock;
        logic                 shift_clock;
        logic                 serial_data;
    } rssod_result_t;

endpackage

[hdl/rssod_row_store.sv]
// Row pattern store: one write port, one read port, cleared by reset.
module rssod_row_store (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [rssod_pkg::ROW_SEL_W-1:0]     wr_row,
    input  logic [rssod_pkg::ROW_BITS_W-1:0]    wr_bits,
    input  logic [rssod_pkg::ROW_SEL_W-1:0]     rd_row,
    output logic [rssod_pkg::ROW_WIDTH-1:0]     rd_bits
);

    logic [rssod_pkg::ROW_WIDTH-1:0] row_mem_reg [rssod_pkg::ROW_COUNT];
    logic [31:0]                     wr_ext;
    logic                            wr_in_range;

    // Drop pattern bits above the row width, ignore rows beyond the store
    assign wr_ext      = 32'(wr_bits);
    assign wr_in_range = {1'b0, wr_row} < (rssod_pkg::ROW_SEL_W + 1)'(rssod_pkg::ROW_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rssod_pkg::ROW_COUNT; i++) begin
                row_mem_reg[i] <= '0;
            end
        end else if (wr_en && wr_in_range) begin
            row_mem_reg[wr_row[rssod_pkg::ROW_IDX_W-1:0]] <=
                wr_ext[rssod_pkg::ROW_WIDTH-1:0];
        end
    end

    // Read row is always inside the store (the scan counter wraps before the end)
    assign rd_bits = row_mem_reg[rd_row[rssod_pkg::ROW_IDX_W-1:0]];

endmodule

[hdl/rssod_sequencer.sv]
// Scan sequencer: walks rows, shift bits and latch phases one tick at a time.
module rssod_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                tick,
    input  rssod_pkg::rssod_cfg_t               cfg,
    input  logic [rssod_pkg::ROW_WIDTH-1:0]     row_bits,
    output logic [rssod_pkg::ROW_SEL_W-1:0]     row_sel,
    output rssod_pkg::rssod_result_t            result
);

    rssod_pkg::scan_phase_t                 phase_reg, phase_next;
    logic [rssod_pkg::ROW_SEL_W-1:0]        row_reg, row_next;
    logic [rssod_pkg::SHIFT_CNT_W-1:0]      shift_reg, shift_next;
    logic                                   half_reg, half_next;
    logic [rssod_pkg::LATCH_CNT_W-1:0]      latch_reg, latch_next;

    logic [rssod_pkg::LATCH_CNT_W-1:0]      latch_inc;
    logic [rssod_pkg::LATCH_CNT_W-1:0]      high_limit;
    logic [rssod_pkg::LATCH_CNT_W-1:0]      gap_limit;
    logic [rssod_pkg::SHIFT_CNT_W:0]        shift_inc;
    logic [rssod_pkg::ROW_SEL_W:0]          row_inc;
    logic [rssod_pkg::ROW_WIDTH-1:0]        row_shifted;
    logic                                   ser;
    logic                                   sclk;
    logic                                   lclk;

    // Zero tick counts behave as one
    assign high_limit = (cfg.latch_high_ticks == '0) ?
                        rssod_pkg::LATCH_CNT_W'(1) :
                        rssod_pkg::LATCH_CNT_W'(cfg.latch_high_ticks);
    assign gap_limit  = (cfg.latch_gap_ticks == '0) ? rssod_pkg::LATCH_CNT_W'(1)
                                                    : cfg.latch_gap_ticks;

    assign latch_inc   = latch_reg + rssod_pkg::LATCH_CNT_W'(1);
    assign shift_inc   = {1'b0, shift_reg} + (rssod_pkg::SHIFT_CNT_W + 1)'(1);
    assign row_inc     = {1'b0, row_reg} + (rssod_pkg::ROW_SEL_W + 1)'(1);
    assign row_shifted = row_bits >> shift_reg;

    // Next state and pin levels for one tick
    always_comb begin
        phase_next = phase_reg;
        row_next   = row_reg;
        shift_next = shift_reg;
        half_next  = half_reg;
        latch_next = latch_reg;
        ser        = 1'b1;
        sclk       = 1'b0;
        lclk       = 1'b0;
        unique case (phase_reg)
            rssod_pkg::PH_LATCH_HIGH: begin
                lclk       = 1'b1;
                latch_next = latch_inc;
                if (latch_inc >= high_limit) begin
                    latch_next = '0;
                    phase_next = rssod_pkg::PH_LATCH_GAP;
                end
            end
            rssod_pkg::PH_LATCH_GAP: begin
                latch_next = latch_inc;
                if (latch_inc >= gap_limit) begin
                    latch_next = '0;
                    phase_next = rssod_pkg::PH_SHIFT;
                    shift_next = '0;
                    half_next  = 1'b0;
                    if (row_inc >= (rssod_pkg::ROW_SEL_W + 1)'(rssod_pkg::ROW_COUNT)) begin
                        row_next = '0;
                    end else begin
                        row_next = row_inc[rssod_pkg::ROW_SEL_W-1:0];
                    end
                end
            end
            rssod_pkg::PH_SHIFT: begin
                // Pattern bits first, then ones to fill the chain
                if (shift_reg < rssod_pkg::SHIFT_CNT_W'(rssod_pkg::ROW_WIDTH)) begin
                    ser = row_shifted[0];
                end
                sclk = half_reg;
                if (!half_reg) begin
                    half_next = 1'b1;
                end else begin
                    half_next = 1'b0;
                    if (shift_inc >= (rssod_pkg::SHIFT_CNT_W + 1)'(rssod_pkg::TOTAL_SHIFTS))
                    begin
                        shift_next = '0;
                        latch_next = '0;
                        phase_next = rssod_pkg::PH_LATCH_HIGH;
                    end else begin
                        shift_next = shift_inc[rssod_pkg::SHIFT_CNT_W-1:0];
                    end
                end
            end
            default: begin
                phase_next = rssod_pkg::PH_SHIFT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rssod_pkg::PH_SHIFT;
            row_reg   <= '0;
            shift_reg <= '0;
            half_reg  <= 1'b0;
            latch_reg <= '0;
        end else if (tick) begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            shift_reg <= shift_next;
            half_reg  <= half_next;
            latch_reg <= latch_next;
        end
    end

    assign row_sel                = row_reg;
    assign result.serial_data     = ser;
    assign result.shift_clock     = sclk;
    assign result.latch_clock     = lclk;
    assign result.output_enable_n = ~cfg.screen_enable;
    assign result.current_row     = row_reg;

endmodule

[hdl/row_scan_shift_out_driver_top.sv]
// Row scan shift-out driver: request and result registers, configuration, checks.
//
// Usage
//   s_ channel: one request per beat. s_tuser says what it is: a tick (one half
//   shift-clock period) or a row write (s_tdata carries row number and pattern).
//   m_ channel: one result per tick, the pin levels for that tick; row writes
//   give no result and do not move the scan.
//   cfg_ channel: register writes (screen enable, latch high and latch gap tick
//   counts), always ready; write only while no request is in flight.
// Timing
//   A request accepted into the request register is taken into the sequencer, and a
//   tick's result into the result register, at the same edge once the output is free;
//   m_tvalid rises straight after that edge. One request per cycle is sustained while
//   m_tready stays high; the sequencer state and row store update once per request.
// Reset
//   The row store clears to zero, the scan restarts at row 0 in the shift phase
//   and the registers return to their defaults (display off, 6 and 55 ticks).
// Stall
//   While m_tready is low a valid result register holds; the request register still
//   drains row writes, and s_tready drops once a tick waits behind a full output.
module row_scan_shift_out_driver_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Requests
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rssod_pkg::S_TDATA_W-1:0]     s_tdata,  // row_select[3:0], row_bits[28:4]
    input  logic                                s_tuser,  // req_type[0]
    // Results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rssod_pkg::M_TDATA_W-1:0]     m_tdata,  // serial_data[0], shift_clock[1],
                                                          // latch_clock[2], output_enable_n[3],
                                                          // current_row[7:4]
    // Configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rssod_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rssod_pkg::CFG_DATA_W-1:0]    cfg_data
);

`include "row_scan_shift_out_driver_top_defines.svh"

    // Request register
    logic                                   in_valid_reg;
    logic                                   in_type_reg;
    logic [rssod_pkg::ROW_SEL_W-1:0]        in_row_reg;
    logic [rssod_pkg::ROW_BITS_W-1:0]       in_bits_reg;

    // Result register
    logic                                   out_valid_reg;
    rssod_pkg::rssod_result_t               out_data_reg;

    // Configuration registers
    rssod_pkg::rssod_cfg_t                  cfg_reg;

    logic                                   out_free;
    logic                                   advance;
    logic                                   tick;
    logic                                   row_wr;
    logic [rssod_pkg::ROW_SEL_W-1:0]        row_sel;
    logic [rssod_pkg::ROW_WIDTH-1:0]        row_bits;
    rssod_pkg::rssod_result_t               result;

    // Handshake control
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && ((in_type_reg == rssod_pkg::REQ_WRITE) || out_free);
    assign tick      = advance && (in_type_reg == rssod_pkg::REQ_TICK);
    assign row_wr    = advance && (in_type_reg == rssod_pkg::REQ_WRITE);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg <= s_tuser;
            in_row_reg  <= s_tdata[rssod_pkg::ROW_SEL_W-1:0];
            in_bits_reg <= s_tdata[rssod_pkg::ROW_SEL_W +: rssod_pkg::ROW_BITS_W];
        end
    end

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_enable    <= 1'b0;
            cfg_reg.latch_high_ticks <= rssod_pkg::LATCH_HIGH_RST;
            cfg_reg.latch_gap_ticks  <= rssod_pkg::LATCH_GAP_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rssod_pkg::CFG_SCREEN_ENABLE: cfg_reg.screen_enable    <= cfg_data[0];
                rssod_pkg::CFG_LATCH_HIGH:
                    cfg_reg.latch_high_ticks <= cfg_data[rssod_pkg::LHIGH_W-1:0];
                rssod_pkg::CFG_LATCH_GAP:
                    cfg_reg.latch_gap_ticks  <= cfg_data[rssod_pkg::LGAP_W-1:0];
                default: ;
            endcase
        end
    end

    rssod_row_store u_row_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (row_wr),
        .wr_row  (in_row_reg),
        .wr_bits (in_bits_reg),
        .rd_row  (row_sel),
        .rd_bits (row_bits)
    );

    rssod_sequencer u_sequencer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tick     (tick),
        .cfg      (cfg_reg),
        .row_bits (row_bits),
        .row_sel  (row_sel),
        .result   (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= tick;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rssod_pkg::M_TDATA_W'(out_data_reg);

    // Checks
    `RSSOD_ASSERT_NEXT(a_tick_gives_result, aclk, aresetn, tick, m_tvalid,
        "tick request did not produce a result")
    `RSSOD_ASSERT_SAME(a_latch_pins, aclk, aresetn,
        m_tvalid && out_data_reg.latch_clock,
        !out_data_reg.shift_clock && out_data_reg.serial_data,
        "latch clock high while shift clock or data not idle")
    `RSSOD_ASSERT_SAME(a_row_in_range, aclk, aresetn, m_tvalid,
        {1'b0, out_data_reg.current_row} <
            (rssod_pkg::ROW_SEL_W + 1)'(rssod_pkg::ROW_COUNT),
        "current row beyond the row store")
    `RSSOD_ASSERT_NEXT(a_write_no_result, aclk, aresetn,
        row_wr && !out_valid_reg, !m_tvalid,
        "row write produced a result")

endmodule

[dv/row_scan_checker.sv]
// Checker for the row scan driver: pin-level prediction and result comparison.
`timescale 1ns / 100ps

module row_scan_checker
    import rssod_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // row_select[3:0], row_bits[28:4]
    input  logic                  s_tuser,   // req_type[0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // serial_data[0], shift_clock[1],
                                             // latch_clock[2], output_enable_n[3],
                                             // current_row[7:4]
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    pending_count,
    output int                    tick_total,
    output int                    write_count,
    output int                    row_moves
);

    // Predicted scanner state
    logic [ROW_WIDTH-1:0]   row_patterns [ROW_COUNT];
    logic [ROW_SEL_W-1:0]   row_ptr;
    logic [SHIFT_CNT_W-1:0] bit_ptr;
    logic                   clk_half;
    scan_phase_t            phase;
    logic [LATCH_CNT_W-1:0] latch_ticks;

    // Register copies
    logic                   show_en;
    logic [LHIGH_W-1:0]     high_ticks;
    logic [LGAP_W-1:0]      gap_ticks;

    // Pin levels still owed by the block, oldest first
    rssod_result_t          pin_queue [$];

    int errs;
    int ticks;
    int writes;
    int moves;

    // Advance the scan by one tick and give the pin levels of that tick
    task automatic step_scan(output rssod_result_t pins);
        int limit;
        pins.serial_data     = 1'b1;
        pins.shift_clock     = 1'b0;
        pins.latch_clock     = 1'b0;
        pins.output_enable_n = ~show_en;
        pins.current_row     = row_ptr;
        case (phase)
            PH_LATCH_HIGH: begin
                pins.latch_clock = 1'b1;
                limit = (high_ticks == 0) ? 1 : int'(high_ticks);
                latch_ticks = latch_ticks + 1'b1;
                if (latch_ticks >= limit) begin
                    latch_ticks = '0;
                    phase = PH_LATCH_GAP;
                end
            end
            PH_LATCH_GAP: begin
                limit = (gap_ticks == 0) ? 1 : int'(gap_ticks);
                latch_ticks = latch_ticks + 1'b1;
                if (latch_ticks >= limit) begin
                    latch_ticks = '0;
                    phase = PH_SHIFT;
                    bit_ptr = '0;
                    clk_half = 1'b0;
                    row_ptr = (row_ptr + 1 >= ROW_COUNT) ? '0 : row_ptr + 1'b1;
                    moves++;
                end
            end
            default: begin
                // data bits first, then ones pad the rest of the chain
                if (bit_ptr < ROW_WIDTH)
                    pins.serial_data = row_patterns[row_ptr][bit_ptr];
                pins.shift_clock = clk_half;
                if (!clk_half) begin
                    clk_half = 1'b1;
                end else begin
                    clk_half = 1'b0;
                    if (bit_ptr + 1 >= TOTAL_SHIFTS) begin
                        bit_ptr = '0;
                        latch_ticks = '0;
                        phase = PH_LATCH_HIGH;
                    end else begin
                        bit_ptr = bit_ptr + 1'b1;
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errs++;
        end
    endtask

    // Watch all three channels on every edge
    always @(posedge aclk) begin
        rssod_result_t want;
        rssod_result_t got;
        logic [ROW_SEL_W-1:0] sel;
        if (!aresetn) begin
            foreach (row_patterns[i])
                row_patterns[i] = '0;
            row_ptr     = '0;
            bit_ptr     = '0;
            clk_half    = 1'b0;
            phase       = PH_SHIFT;
            latch_ticks = '0;
            show_en     = 1'b0;
            high_ticks  = LATCH_HIGH_RST;
            gap_ticks   = LATCH_GAP_RST;
            pin_queue.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SCREEN_ENABLE: show_en = cfg_data[0];
                    CFG_LATCH_HIGH:    high_ticks = cfg_data[LHIGH_W-1:0];
                    CFG_LATCH_GAP:     gap_ticks = cfg_data[LGAP_W-1:0];
                    default: ;
                endcase
            end

            // results come after their request, through the request and result registers
            if (m_tvalid && m_tready) begin
                got = rssod_result_t'(m_tdata);
                if (pin_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                    errs++;
                end else begin
                    want = pin_queue.pop_front();
                    check_field("serial_data", want.serial_data, got.serial_data);
                    check_field("shift_clock", want.shift_clock, got.shift_clock);
                    check_field("latch_clock", want.latch_clock, got.latch_clock);
                    check_field("output_enable_n", want.output_enable_n,
                                got.output_enable_n);
                    check_field("current_row", want.current_row, got.current_row);
                end
            end

            // requests: ticks owe a result, row writes update the store
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_TICK) begin
                    step_scan(want);
                    pin_queue.push_back(want);
                    ticks++;
                end else begin
                    sel = s_tdata[ROW_SEL_W-1:0];
                    if (sel < ROW_COUNT)
                        row_patterns[sel] = s_tdata[ROW_SEL_W +: ROW_BITS_W];
                    writes++;
                end
            end
        end
        error_count   <= errs;
        pending_count <= pin_queue.size();
        tick_total    <= ticks;
        write_count   <= writes;
        row_moves     <= moves;
    end

endmodule

[dv/testbench.sv]
// Top of the row scan driver bench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 100ps

module testbench;
    import rssod_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int MAX_WAIT     = 11;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_CYCLES  = 160;
    localparam int WRITE_PCT    = 8;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // row_select[3:0], row_bits[28:4]
    logic                  s_tuser   = REQ_TICK;  // req_type[0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;   // serial_data[0], shift_clock[1], latch_clock[2],
                                      // output_enable_n[3], current_row[7:4]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int error_count;
    int pending_count;
    int tick_total;
    int write_count;
    int row_moves;
    int settings;
    int send_burst;

    always #1 aclk = ~aclk;

    row_scan_shift_out_driver_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    row_scan_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count),
        .tick_total    (tick_total),
        .write_count   (write_count),
        .row_moves     (row_moves)
    );

    // Idle cycles before the next request; now and then a run with none
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst = 20;
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // One register write; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_scan(input logic en, input logic [LHIGH_W-1:0] high,
                                input logic [LGAP_W-1:0] gap);
        write_reg(CFG_SCREEN_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_LATCH_HIGH, CFG_DATA_W'(high));
        write_reg(CFG_LATCH_GAP, gap);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // One request on the s_ channel
    task automatic send_req(input logic kind, input logic [ROW_SEL_W-1:0] sel,
                            input logic [ROW_BITS_W-1:0] bits);
        int gap;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({bits, sel});
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly ticks, some row writes, a few aimed past the last row
    task automatic run_phase(input int count);
        logic kind;
        logic [ROW_SEL_W-1:0] sel;
        for (int i = 0; i < count; i++) begin
            kind = ($urandom_range(0, 99) < WRITE_PCT) ? REQ_WRITE : REQ_TICK;
            sel  = ($urandom_range(0, 9) == 0) ?
                   ROW_SEL_W'($urandom_range(ROW_COUNT, 15)) :
                   ROW_SEL_W'($urandom_range(0, ROW_COUNT - 1));
            send_req(kind, sel, ROW_BITS_W'($urandom));
        end
    endtask

    // Wait until every tick result is in and any trailing write has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Result side: random back-pressure plus one long hold-off
    initial begin
        int gap;
        int taken;
        int burst;
        taken = 0;
        burst = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == HOLD_AFTER)
                gap = HOLD_CYCLES;
            else
                gap = draw_wait(burst);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    // Main sequence
    initial begin
        settings   = 0;
        send_burst = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // unused register index, then a short scan setting
        write_reg(CFG_SPARE, 10'h2AA);
        program_scan(1'b1, 8'd1, 10'd1);

        // directed row patterns, including rows past the end of the store
        send_req(REQ_WRITE, 4'd0, 25'h1FFFFFF);
        send_req(REQ_WRITE, 4'd1, 25'h0000000);
        send_req(REQ_WRITE, 4'd2, 25'h1555555);
        send_req(REQ_WRITE, 4'd3, 25'h0AAAAAA);
        send_req(REQ_WRITE, 4'd4, 25'h0000001);
        send_req(REQ_WRITE, 4'd5, 25'h1000000);
        send_req(REQ_WRITE, 4'd6, 25'h0F0F0F0);
        send_req(REQ_WRITE, 4'd7, ROW_BITS_W'($urandom));
        send_req(REQ_WRITE, 4'd8, ROW_BITS_W'($urandom));
        send_req(REQ_WRITE, 4'd9, 25'h1234567);
        send_req(REQ_WRITE, 4'd10, 25'h1FFFFFF);
        send_req(REQ_WRITE, 4'd15, 25'h1FFFFFF);
        for (int i = 0; i < 12; i++)
            send_req(REQ_TICK, '0, '0);

        run_phase(80);

        // zero latch counts behave as one tick
        drain();
        program_scan(1'b0, 8'd0, 10'd0);
        run_phase(80);

        // longest latch phases
        drain();
        program_scan(1'b1, 8'd255, 10'd1023);
        run_phase(50);

        // shrink the counts again after the longest latch phases
        drain();
        program_scan(1'b1, 8'd2, 10'd1);
        run_phase(80);

        for (int p = 0; p < 2; p++) begin
            drain();
            program_scan(1'($urandom_range(0, 1)), LHIGH_W'($urandom_range(1, 5)),
                         LGAP_W'($urandom_range(1, 8)));
            run_phase(70);
        end

        drain();
        $display("Run covered %0d ticks and %0d row writes under %0d register settings,",
                 tick_total, write_count, settings);
        $display("with the scan crossing %0d row boundaries.", row_moves);
        if (error_count == 0) begin
            $display("row_scan_shift_out_driver_top verification clean");
        end else begin
            $display("row_scan_shift_out_driver_top verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("row_scan_shift_out_driver_top verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/rssod_pkg.sv
hdl/rssod_row_store.sv
hdl/rssod_sequencer.sv
hdl/row_scan_shift_out_driver_top.sv
dv/row_scan_checker.sv
dv/testbench.sv
